/* rtl/clh_pkg.sv */
// Shared types and constants for the CANopen encoder link handler.
package clh_pkg;

    localparam int NODE_W    = 7;
    localparam int TICK_W    = 16;
    localparam int ID_W      = 11;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 16;
    localparam int PAYLOAD_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

    localparam logic [NODE_W-1:0] NODE_ID_RESET       = 7'd1;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RESET = 16'd100;

    localparam logic [ID_W-1:0] ID_BOOTUP      = 11'h700;
    localparam logic [ID_W-1:0] ID_SDO_REPLY   = 11'd1408;
    localparam logic [ID_W-1:0] ID_PDO         = 11'd384;
    localparam logic [ID_W-1:0] ID_SDO_REQUEST = 11'd1536;
    localparam logic [ID_W-1:0] ID_NMT         = 11'd0;

    localparam logic [PAYLOAD_W-1:0] SDO_PAYLOAD = 64'h0000_000A_0062_0022;
    localparam logic [BYTE_W-1:0]    NMT_START   = 8'h01;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_DELTA = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic [TICK_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   frame_id;
        logic [BYTE_W-1:0] data_low;
        logic [BYTE_W-1:0] data_high;
    } t_item;

    typedef struct packed {
        logic                 result_kind;
        logic [ID_W-1:0]      tx_id;
        logic [PAYLOAD_W-1:0] tx_payload;
        logic [POS_W-1:0]     tick_delta;
        logic                 timed_out;
    } t_result;

endpackage

/* rtl/clh_cfg_regs.sv */
// Configuration registers: node number and watchdog reload value.
module clh_cfg_regs import clh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODE_ID:       n_cfg.node_id       = i_cfg_data[NODE_W-1:0];
                CFG_TIMEOUT_TICKS: n_cfg.timeout_ticks = i_cfg_data[TICK_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_id       <= NODE_ID_RESET;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/clh_proc.sv */
// Frame decode, watchdog and position state; builds at most one result per word.
module clh_proc import clh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [TICK_W-1:0] r_watchdog;
    logic [TICK_W-1:0] n_watchdog;
    logic [POS_W-1:0]  r_last_pos;
    logic [POS_W-1:0]  n_last_pos;

    logic [ID_W-1:0]   node_ext;
    logic [TICK_W-1:0] wd_dec;
    logic [POS_W-1:0]  pos;
    logic              is_boot;
    logic              is_reply;
    logic              is_pdo;

    assign node_ext = {{(ID_W-NODE_W){1'b0}}, i_cfg.node_id};
    assign wd_dec   = r_watchdog - 1'b1;
    assign pos      = {i_item.data_high, i_item.data_low};
    assign is_boot  = i_item.frame_id == (ID_BOOTUP + node_ext);
    assign is_reply = i_item.frame_id == (ID_SDO_REPLY + node_ext);
    assign is_pdo   = i_item.frame_id == (ID_PDO + node_ext);

    always_comb begin
        n_watchdog  = r_watchdog;
        n_last_pos  = r_last_pos;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_item.command == CMD_TICK) begin
            n_watchdog = wd_dec;
            if (wd_dec == '0) begin
                n_watchdog       = i_cfg.timeout_ticks;
                n_last_pos       = '0;
                o_res_valid      = 1'b1;
                o_res.tx_id      = ID_SDO_REQUEST + node_ext;
                o_res.tx_payload = SDO_PAYLOAD;
                o_res.timed_out  = 1'b1;
            end
        end else if (is_boot) begin
            n_watchdog       = i_cfg.timeout_ticks;
            o_res_valid      = 1'b1;
            o_res.tx_id      = ID_SDO_REQUEST + node_ext;
            o_res.tx_payload = SDO_PAYLOAD;
        end else if (is_reply) begin
            n_watchdog       = i_cfg.timeout_ticks;
            o_res_valid      = 1'b1;
            o_res.tx_id      = ID_NMT;
            o_res.tx_payload = {{(PAYLOAD_W-NODE_W-1-BYTE_W){1'b0}}, 1'b0,
                                i_cfg.node_id, NMT_START};
        end else if (is_pdo) begin
            n_watchdog        = i_cfg.timeout_ticks;
            n_last_pos        = pos;
            o_res_valid       = 1'b1;
            o_res.result_kind = KIND_DELTA;
            o_res.tick_delta  = pos - r_last_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watchdog <= TIMEOUT_TICKS_RESET;
            r_last_pos <= '0;
        end else if (i_fire) begin
            r_watchdog <= n_watchdog;
            r_last_pos <= n_last_pos;
        end
    end

endmodule

/* rtl/canopen_encoder_link_handler_core.sv */
// CANopen encoder link handler: top level with input and result registers.
// A word accepted passes through the input register and, when it yields a
// result, the result register, from which it is taken.
// Throughput: one word per cycle; the input register moves on whenever the
// result register is empty or being taken.
// Reset (synchronous, active low) clears both valid bits, loads node 1,
// a 100-tick watchdog and a zero last position.
module canopen_encoder_link_handler_core import clh_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_command,
    input  logic [ID_W-1:0]            i_frame_id,
    input  logic [BYTE_W-1:0]          i_data_low,
    input  logic [BYTE_W-1:0]          i_data_high,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_result_kind,
    output logic [ID_W-1:0]            o_tx_id,
    output logic [PAYLOAD_W-1:0]       o_tx_payload,
    output logic signed [POS_W-1:0]    o_tick_delta,
    output logic                       o_timed_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DAT_W-1:0]       i_cfg_data
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    logic    n_out_valid;

    t_cfg    cfg;
    t_result res;
    logic    res_valid;
    logic    fire;

    assign fire        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign o_cfg_ready = 1'b1;

    clh_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    clh_proc u_proc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= {i_command, i_frame_id, i_data_low, i_data_high};
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (fire && res_valid) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out.result_kind;
    assign o_tx_id       = r_out.tx_id;
    assign o_tx_payload  = r_out.tx_payload;
    assign o_tick_delta  = r_out.tick_delta;
    assign o_timed_out   = r_out.timed_out;

endmodule

/* rtl/clh_checker.sv */
// Port-level checks for the link handler core, bound to the top level.
module clh_checker import clh_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_result_kind,
    input logic [ID_W-1:0]      o_tx_id,
    input logic [PAYLOAD_W-1:0] o_tx_payload,
    input logic [POS_W-1:0]     o_tick_delta,
    input logic                 o_timed_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tx_payload)
            && $stable(o_tick_delta) && $stable(o_tx_id))
        else $error("stalled result word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_delta_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_DELTA |->
            o_tx_id == '0 && o_tx_payload == '0 && !o_timed_out)
        else $error("delta word carries transmit fields");

    a_tx_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_TX |-> o_tick_delta == '0 &&
            (o_tx_payload == SDO_PAYLOAD ||
             (o_tx_id == ID_NMT && !o_timed_out &&
              o_tx_payload[BYTE_W-1:0] == NMT_START)))
        else $error("malformed transmit word");

endmodule

bind canopen_encoder_link_handler_core clh_checker u_clh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_kind (o_result_kind),
    .o_tx_id       (o_tx_id),
    .o_tx_payload  (o_tx_payload),
    .o_tick_delta  (o_tick_delta),
    .o_timed_out   (o_timed_out)
);
